// File: rtl/core/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and codes of the indexed list store
// Field widths, action and status codes, and the command word that passes
// from the front end to the list engine.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int ACTION_W    = 3;
    localparam int POS_W       = 6;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 48;
    localparam int CMD_Q_DEPTH = 2;

    localparam logic [ACTION_W-1:0] ACT_GET      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_TAIL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_ALL = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] item_value;
    } cmd_t;

endpackage

// File: rtl/core/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core: linked list of signed values in a slot store
// Front stage, command queue and list engine with a registered result.
// ----------------------------------------------------------------------------
// flow: get and remove walk one link per cycle from the list head; the engine takes a
//   new command only after the result of the last one is loaded, while the front stage
//   and command queue hold further commands; read-all loads its results one by one
//   through S_RD and S_RESP and waits in S_RESP under m_tready stalls
// reset: list empty, free chain in slot order at once through per-slot valid
//   bits; no clearing pass, items accepted from the first cycle after reset
module indexed_list_store_core
#(
    parameter int DEPTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action [2:0], position [8:3], item_value [40:9], zero pad above
    input  logic [ils_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_value [31:0]
    output logic signed [ils_pkg::VALUE_W-1:0]  m_tdata,
    // status [1:0]
    output logic [ils_pkg::STATUS_W-1:0]        m_tuser,
    output logic                                m_tlast
);

    logic          front_valid;
    logic          front_ready;
    ils_pkg::cmd_t front_cmd;
    logic          queue_valid;
    logic          queue_ready;
    ils_pkg::cmd_t queue_cmd;

    ils_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    ils_cmd_fifo u_cmd_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    ils_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: rtl/core/ils_front.sv
// ----------------------------------------------------------------------------
// ils_front: input stage of the indexed list store
// Takes input transfers, drops unused action codes and holds one command
// for the command queue.
// ----------------------------------------------------------------------------
module ils_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // action [2:0], position [8:3], item_value [40:9], zero pad above
    input  logic [ils_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output ils_pkg::cmd_t                 cmd
);

    logic          cmd_valid_reg;
    logic          cmd_valid_next;
    ils_pkg::cmd_t cmd_reg;
    ils_pkg::cmd_t in_cmd;
    logic          known_action;

    assign in_cmd.action     = s_tdata[2:0];
    assign in_cmd.position   = s_tdata[8:3];
    assign in_cmd.item_value = s_tdata[40:9];

    assign known_action = (in_cmd.action inside
                           {[ils_pkg::ACT_GET:ils_pkg::ACT_READ_ALL]});

    assign s_tready  = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (s_tvalid && s_tready)
        begin
            // unused codes are taken and discarded
            cmd_valid_next = known_action;
        end
        else if (cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= in_cmd;
        end
    end

endmodule

// File: rtl/core/ils_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ils_cmd_fifo: command queue of the indexed list store
// Short first-in first-out queue between the front end and the list engine.
// ----------------------------------------------------------------------------
module ils_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ils_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ils_pkg::cmd_t pop_data
);

    localparam int PTR_W = (ils_pkg::CMD_Q_DEPTH > 1) ? $clog2(ils_pkg::CMD_Q_DEPTH) : 1;
    localparam int FILL_W = $clog2(ils_pkg::CMD_Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ils_pkg::CMD_Q_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(ils_pkg::CMD_Q_DEPTH);

    ils_pkg::cmd_t     entries_reg [ils_pkg::CMD_Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != FULL_FILL);
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/ils_back.sv
// ----------------------------------------------------------------------------
// ils_back: list engine of the indexed list store
// Walks and edits the linked slot store one link read per cycle and drives
// the result register.
// ----------------------------------------------------------------------------
module ils_back
#(
    parameter int DEPTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  ils_pkg::cmd_t                       cmd,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_value [31:0]
    output logic signed [ils_pkg::VALUE_W-1:0]  m_tdata,
    // status [1:0]
    output logic [ils_pkg::STATUS_W-1:0]        m_tuser,
    output logic                                m_tlast
);

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WALK   = 4'd1;
    localparam logic [3:0] S_GETV   = 4'd2;
    localparam logic [3:0] S_UNLINK = 4'd3;
    localparam logic [3:0] S_FREE   = 4'd4;
    localparam logic [3:0] S_INS    = 4'd5;
    localparam logic [3:0] S_TAIL   = 4'd6;
    localparam logic [3:0] S_RD     = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    // slot store
    logic [SLOT_W-1:0]                link_mem [DEPTH];
    logic signed [ils_pkg::VALUE_W-1:0] value_mem [DEPTH];
    logic [DEPTH-1:0]                 link_valid_reg;
    logic [SLOT_W-1:0]                link_rdata_reg;
    logic                             link_rvalid_reg;
    logic signed [ils_pkg::VALUE_W-1:0] value_rdata_reg;
    logic [SLOT_W-1:0]                link_q;

    logic                             link_we;
    logic [SLOT_W-1:0]                link_waddr;
    logic [SLOT_W-1:0]                link_wdata;
    logic                             value_we;

    // control
    logic [3:0]                    state_reg, state_next;
    logic [SLOT_W-1:0]             first_reg, first_next;
    logic [SLOT_W-1:0]             last_reg, last_next;
    logic [SLOT_W-1:0]             free_reg, free_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [SLOT_W-1:0]             cur_reg, cur_next;
    logic [SLOT_W-1:0]             prev_reg, prev_next;
    logic [CNT_W-1:0]              steps_reg, steps_next;
    logic [ils_pkg::ACTION_W-1:0]  op_reg, op_next;
    logic                          pos_zero_reg, pos_zero_next;
    logic signed [ils_pkg::VALUE_W-1:0] ins_value_reg, ins_value_next;
    logic signed [ils_pkg::VALUE_W-1:0] resp_value_reg, resp_value_next;
    logic [ils_pkg::STATUS_W-1:0]  resp_status_reg, resp_status_next;
    logic                          resp_last_reg, resp_last_next;

    // result register
    logic                               out_valid_reg;
    logic signed [ils_pkg::VALUE_W-1:0] out_value_reg;
    logic [ils_pkg::STATUS_W-1:0]       out_status_reg;
    logic                               out_last_reg;
    logic                               out_load;

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;

    // a slot never written still holds its place in the reset free chain
    assign link_q = link_rvalid_reg ? link_rdata_reg : slot_after(cur_reg);

    assign pos_c = CMP_W'(cmd.position);
    assign cnt_c = CMP_W'(count_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        free_next        = free_reg;
        count_next       = count_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        steps_next       = steps_reg;
        op_next          = op_reg;
        pos_zero_next    = pos_zero_reg;
        ins_value_next   = ins_value_reg;
        resp_value_next  = resp_value_reg;
        resp_status_next = resp_status_reg;
        resp_last_next   = resp_last_reg;
        link_we          = 1'b0;
        link_waddr       = cur_reg;
        link_wdata       = '0;
        value_we         = 1'b0;
        out_load         = 1'b0;
        cmd_ready        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next          = cmd.action;
                    pos_zero_next    = (cmd.position == '0);
                    ins_value_next   = cmd.item_value;
                    resp_value_next  = '0;
                    resp_status_next = ils_pkg::ST_OK;
                    resp_last_next   = 1'b1;
                    case (cmd.action)
                        ils_pkg::ACT_GET:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                resp_value_next  = '1;
                                resp_status_next = ils_pkg::ST_RANGE;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                cur_next   = first_reg;
                                steps_next = CNT_W'(cmd.position);
                                state_next = S_WALK;
                            end
                        end
                        ils_pkg::ACT_INS_HEAD, ils_pkg::ACT_INS_TAIL:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                resp_status_next = ils_pkg::ST_FULL;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                cur_next   = free_reg;
                                state_next = S_INS;
                            end
                        end
                        ils_pkg::ACT_REMOVE:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                resp_status_next = ils_pkg::ST_RANGE;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                // stop at the predecessor, or at the head itself
                                cur_next   = first_reg;
                                steps_next = (cmd.position == '0) ? '0
                                           : CNT_W'(cmd.position - 1'b1);
                                state_next = S_WALK;
                            end
                        end
                        ils_pkg::ACT_READ_ALL:
                        begin
                            if (count_reg == '0)
                            begin
                                resp_status_next = ils_pkg::ST_EMPTY;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                cur_next   = first_reg;
                                steps_next = count_reg;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    if (op_reg == ils_pkg::ACT_GET)
                    begin
                        state_next = S_GETV;
                    end
                    else if (pos_zero_reg)
                    begin
                        first_next = link_q;
                        if (count_reg == CNT_W'(1))
                        begin
                            last_next = '0;
                        end
                        state_next = S_FREE;
                    end
                    else
                    begin
                        prev_next  = cur_reg;
                        cur_next   = link_q;
                        state_next = S_UNLINK;
                    end
                end
                else
                begin
                    cur_next   = link_q;
                    steps_next = steps_reg - 1'b1;
                end
            end

            S_GETV:
            begin
                resp_value_next = value_rdata_reg;
                state_next      = S_RESP;
            end

            S_UNLINK:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_q;
                if (cur_reg == last_reg)
                begin
                    last_next = prev_reg;
                end
                state_next = S_FREE;
            end

            S_FREE:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = free_reg;
                free_next  = cur_reg;
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end

            S_INS:
            begin
                free_next = link_q;
                value_we  = 1'b1;
                link_we   = 1'b1;
                if (op_reg == ils_pkg::ACT_INS_HEAD)
                begin
                    link_wdata = first_reg;
                    first_next = cur_reg;
                    if (count_reg == '0)
                    begin
                        last_next = cur_reg;
                    end
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
                else if (count_reg == '0)
                begin
                    first_next = cur_reg;
                    last_next  = cur_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end

            S_TAIL:
            begin
                // hook the new slot behind the old tail
                link_we    = 1'b1;
                link_waddr = last_reg;
                link_wdata = cur_reg;
                last_next  = cur_reg;
                count_next = count_reg + 1'b1;
                state_next = S_RESP;
            end

            S_RD:
            begin
                resp_value_next  = value_rdata_reg;
                resp_status_next = ils_pkg::ST_OK;
                resp_last_next   = (steps_reg == CNT_W'(1));
                state_next       = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (resp_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = link_q;
                        steps_next = steps_reg - 1'b1;
                        state_next = S_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            first_reg       <= '0;
            last_reg        <= '0;
            free_reg        <= '0;
            count_reg       <= '0;
            cur_reg         <= '0;
            resp_last_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            link_valid_reg  <= '0;
            link_rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            first_reg       <= first_next;
            last_reg        <= last_next;
            free_reg        <= free_next;
            count_reg       <= count_next;
            cur_reg         <= cur_next;
            resp_last_reg   <= resp_last_next;
            link_rvalid_reg <= link_valid_reg[cur_next];
            if (link_we)
            begin
                link_valid_reg[link_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg        <= prev_next;
        steps_reg       <= steps_next;
        op_reg          <= op_next;
        pos_zero_reg    <= pos_zero_next;
        ins_value_reg   <= ins_value_next;
        resp_value_reg  <= resp_value_next;
        resp_status_reg <= resp_status_next;
        if (out_load)
        begin
            out_value_reg  <= resp_value_reg;
            out_status_reg <= resp_status_reg;
            out_last_reg   <= resp_last_reg;
        end
    end

    // link and value memories, read data registered at the slot being visited
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[cur_next];
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[cur_reg] <= ins_value_reg;
        end
        value_rdata_reg <= value_mem[cur_next];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> (count_reg != FULL_CNT))
        else $error("insert started on a full list");

    a_free_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("slot freed without count decrement");

    a_rd_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (steps_reg != '0))
        else $error("read-out beyond the list length");

endmodule
